FILE: rtl/bmaf_pkg.sv
// Shared constants for the block moving-average filter.
// No dependencies; imported by block_moving_average_filter.
`timescale 1ns / 1ps

package bmaf_pkg;

    // Fixed field widths of the interface
    localparam int WS_W  = 6;   // window_size register
    localparam int BLK_W = 13;  // block_length field

    // Longest block handled; longer lengths saturate
    localparam int MAX_BLOCK = 4096;

    // Position counters hold 0 .. MAX_BLOCK
    localparam int IDX_W = $clog2(MAX_BLOCK + 1);

    // Signed width for span bound arithmetic
    localparam int POS_W = IDX_W + 2;

endpackage

FILE: rtl/block_moving_average_filter.sv
// Block moving-average filter with shrinking windows at the block edges.
// Depends on bmaf_pkg (field widths, block length limit).
// Single module: sequencer, history ring, running sum and serial divider.
`timescale 1ns / 1ps

//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  input     | in        | in_valid / in_stall    | sample, block_length
//  output    | out       | out_valid / out_stall  | mean, last
//  config    | in        | cfg_wr_en              | cfg_wr_data (window_size)
//
//  Each input word passes S_IDLE, S_DROP, S_ADD and S_PLAN for the running-sum
//  update and exit, and each result passes S_CLIP, S_DINIT, S_DIV and S_EMIT:
//  the restoring divider yields one quotient bit per cycle over MAG_W bits
//  (21 at defaults). Edge results whose span is not the full window also pass
//  S_SPAN, reading the span samples back from the ring.
//  in_stall is high from acceptance until the word's results are all queued.
//  A result waits in the output register under out_stall; the next result
//  is computed meanwhile and held in S_EMIT until the register frees.
//  rst_n clears all control state; the history ring needs no clearing.

module block_moving_average_filter
    import bmaf_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [WS_W-1:0]               cfg_wr_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [BLK_W-1:0]              block_length,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] mean,
    output logic                          last
);

    // Derived sizes
    localparam int WW          = $clog2(MAX_WINDOW + 1);              // holds 0..MAX_WINDOW
    localparam int PW          = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int MAG_W       = SUM_W - 1;
    localparam int DCNT_W      = $clog2(MAG_W + 1);
    localparam int MAX_RESULTS = MAX_WINDOW / 2 + 1;
    localparam int KW          = $clog2(MAX_RESULTS + 1);

    localparam logic signed [POS_W-1:0] ZERO_S = '0;
    localparam logic signed [POS_W-1:0] ONE_S  = POS_W'(1);
    localparam logic signed [POS_W-1:0] MWM1_S = POS_W'(MAX_WINDOW - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DROP,
        S_ADD,
        S_PLAN,
        S_CLIP,
        S_SPAN,
        S_DINIT,
        S_DIV,
        S_EMIT
    } state_t;

    // Control and datapath registers
    state_t                   state_reg;
    logic [WS_W-1:0]          window_size_reg;
    logic [IDX_W-1:0]         in_idx_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic [WW-1:0]            w_reg;
    logic [PW-1:0]            wp_reg;
    logic [IDX_W-1:0]         len_reg;
    logic                     fin_reg;
    logic [KW-1:0]            k_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                     drop_reg;
    logic signed [SUM_W-1:0]  window_sum_reg;
    logic signed [POS_W-1:0]  lo_reg;
    logic signed [POS_W-1:0]  hi_reg;
    logic [WW-1:0]            cnt_reg;
    logic [PW-1:0]            span_addr_reg;
    logic [WW-1:0]            span_left_reg;
    logic                     pend_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic [MAG_W-1:0]         quo_reg;
    logic [WW-1:0]            rem_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic                     out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg;
    logic                     last_reg;

    // History ring
    logic [SAMPLE_BITS-1:0]   hist_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]   rd_data_reg;
    logic                     mem_re;
    logic                     mem_we;
    logic [PW-1:0]            rd_addr;

    // Ring slot that lies d positions behind the current write slot
    function automatic logic [PW-1:0] slot_back(input logic [PW-1:0] wp,
                                                input logic [WW:0]   d);
        logic [WW:0] wpx;
        logic [WW:0] res;
        wpx = (WW+1)'(wp);
        if (wpx >= d)
            res = wpx - d;
        else
            res = wpx + (WW+1)'(MAX_WINDOW) - d;
        return res[PW-1:0];
    endfunction

    // Ring pointer advance with wrap
    function automatic logic [PW-1:0] slot_next(input logic [PW-1:0] p);
        if (p == PW'(MAX_WINDOW - 1))
            return '0;
        else
            return p + PW'(1);
    endfunction

    // Input word decode: saturated block length, final flag, latched window
    logic [IDX_W-1:0] blk_sat;
    logic [IDX_W:0]   i_plus1;
    logic             fin_c;
    logic [WW-1:0]    ws_c;
    logic [WW-1:0]    w_new;

    always_comb
    begin
        if (block_length == '0)
            blk_sat = IDX_W'(1);
        else if (32'(block_length) > MAX_BLOCK)
            blk_sat = IDX_W'(MAX_BLOCK);
        else
            blk_sat = IDX_W'(block_length);

        i_plus1 = (IDX_W+1)'(in_idx_reg) + (IDX_W+1)'(1);
        fin_c   = (i_plus1 >= (IDX_W+1)'(blk_sat));

        if (window_size_reg == '0)
            ws_c = WW'(1);
        else if (32'(window_size_reg) > MAX_WINDOW)
            ws_c = WW'(MAX_WINDOW);
        else
            ws_c = WW'(window_size_reg);

        if (IDX_W'(ws_c) < blk_sat)
            w_new = ws_c;
        else
            w_new = WW'(blk_sat);
    end

    // Signed views of the positions
    logic signed [POS_W-1:0] n_s;
    logic signed [POS_W-1:0] i_s;
    logic signed [POS_W-1:0] h_s;
    logic signed [POS_W-1:0] w_s;
    logic signed [POS_W-1:0] len_s;

    assign n_s   = $signed(POS_W'(out_idx_reg));
    assign i_s   = $signed(POS_W'(in_idx_reg));
    assign h_s   = $signed(POS_W'(w_reg >> 1));
    assign w_s   = $signed(POS_W'(w_reg));
    assign len_s = $signed(POS_W'(len_reg));

    // Raw span of the next output and the stop test
    logic signed [POS_W-1:0] lo_raw;
    logic signed [POS_W-1:0] hi_raw;
    logic                    stop_c;

    always_comb
    begin
        if (n_s + h_s >= len_s)
        begin
            lo_raw = n_s - h_s;
            hi_raw = len_s - ONE_S;
        end
        else if (n_s < h_s)
        begin
            lo_raw = ZERO_S;
            hi_raw = n_s + h_s - ONE_S;
        end
        else
        begin
            lo_raw = n_s - h_s;
            hi_raw = n_s - h_s + w_s - ONE_S;
        end
        stop_c = (out_idx_reg > in_idx_reg) || (32'(k_reg) >= MAX_RESULTS) ||
                 (!fin_reg && (hi_raw > i_s));
    end

    // Span clipping to received samples and to the ring depth
    logic signed [POS_W-1:0] hi_c1;
    logic signed [POS_W-1:0] hi_c;
    logic signed [POS_W-1:0] lo_c1;
    logic signed [POS_W-1:0] lo_c2;
    logic signed [POS_W-1:0] lo_c;
    logic signed [POS_W-1:0] lo_floor;
    logic signed [POS_W-1:0] cnt_s;
    logic signed [POS_W-1:0] dist_s;
    logic [WW-1:0]           cnt_c;
    logic                    use_ws;

    always_comb
    begin
        hi_c1    = (hi_reg > i_s) ? i_s : hi_reg;
        hi_c     = (hi_c1 < ZERO_S) ? ZERO_S : hi_c1;
        lo_c1    = (lo_reg < ZERO_S) ? ZERO_S : lo_reg;
        lo_floor = i_s - MWM1_S;
        lo_c2    = (lo_c1 < lo_floor) ? lo_floor : lo_c1;
        lo_c     = (lo_c2 > hi_c) ? hi_c : lo_c2;
        cnt_s    = hi_c - lo_c + ONE_S;
        dist_s   = i_s - lo_c;
        cnt_c    = cnt_s[WW-1:0];
        use_ws   = (cnt_c == w_reg) && (hi_c == i_s);
    end

    // Divider step and operand prep
    logic [WW:0]             div_shift;
    logic [WW+1:0]           div_diff;
    logic                    acc_neg;
    logic signed [SUM_W-1:0] acc_abs;
    logic [MAG_W-1:0]        quo_signed;

    always_comb
    begin
        div_shift  = {rem_reg, quo_reg[MAG_W-1]};
        div_diff   = {1'b0, div_shift} - (WW+2)'(cnt_reg);
        acc_neg    = acc_reg[SUM_W-1];
        acc_abs    = acc_neg ? -acc_reg : acc_reg;
        quo_signed = neg_reg ? -quo_reg : quo_reg;
    end

    // Ring port control
    assign mem_re  = (state_reg == S_DROP) ||
                     ((state_reg == S_SPAN) && (span_left_reg != '0));
    assign mem_we  = (state_reg == S_ADD);
    assign rd_addr = (state_reg == S_DROP) ? slot_back(wp_reg, (WW+1)'(w_reg))
                                           : span_addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[wp_reg] <= sample_reg;
        if (mem_re)
            rd_data_reg <= hist_mem[rd_addr];
    end

    // Sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WS_W'(1);
            in_idx_reg      <= '0;
            out_idx_reg     <= '0;
            w_reg           <= '0;
            wp_reg          <= '0;
            len_reg         <= '0;
            fin_reg         <= 1'b0;
            k_reg           <= '0;
            sample_reg      <= '0;
            drop_reg        <= 1'b0;
            window_sum_reg  <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            cnt_reg         <= '0;
            span_addr_reg   <= '0;
            span_left_reg   <= '0;
            pend_reg        <= 1'b0;
            acc_reg         <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            neg_reg         <= 1'b0;
            dcnt_reg        <= '0;
            out_valid_reg   <= 1'b0;
            mean_reg        <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                window_size_reg <= cfg_wr_data;

            // output word taken downstream; S_EMIT handles its own refill
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                // take one input word
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample;
                        fin_reg    <= fin_c;
                        len_reg    <= fin_c ? i_plus1[IDX_W-1:0] : blk_sat;
                        k_reg      <= '0;
                        if (in_idx_reg == '0)
                        begin
                            w_reg          <= w_new;
                            window_sum_reg <= '0;
                        end
                        state_reg <= S_DROP;
                    end
                end

                // leaving sample read from the ring
                S_DROP:
                begin
                    drop_reg  <= (32'(in_idx_reg) >= 32'(w_reg));
                    state_reg <= S_ADD;
                end

                // running sum update, new sample written
                S_ADD:
                begin
                    if (drop_reg)
                        window_sum_reg <= window_sum_reg
                                          - SUM_W'($signed(rd_data_reg))
                                          + SUM_W'(sample_reg);
                    else
                        window_sum_reg <= window_sum_reg + SUM_W'(sample_reg);
                    state_reg <= S_PLAN;
                end

                // next output span, or end of this word
                S_PLAN:
                begin
                    if (stop_c)
                    begin
                        if (fin_reg)
                        begin
                            in_idx_reg     <= '0;
                            out_idx_reg    <= '0;
                            window_sum_reg <= '0;
                            wp_reg         <= '0;
                        end
                        else
                        begin
                            in_idx_reg <= in_idx_reg + IDX_W'(1);
                            wp_reg     <= slot_next(wp_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        lo_reg    <= lo_raw;
                        hi_reg    <= hi_raw;
                        state_reg <= S_CLIP;
                    end
                end

                // clip span; full window uses the running sum
                S_CLIP:
                begin
                    cnt_reg       <= cnt_c;
                    span_addr_reg <= slot_back(wp_reg, dist_s[WW:0]);
                    span_left_reg <= cnt_c;
                    pend_reg      <= 1'b0;
                    if (use_ws)
                    begin
                        acc_reg   <= window_sum_reg;
                        state_reg <= S_DINIT;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        state_reg <= S_SPAN;
                    end
                end

                // walk the span through the ring, one sample a cycle
                S_SPAN:
                begin
                    if (pend_reg)
                        acc_reg <= acc_reg + SUM_W'($signed(rd_data_reg));
                    if (span_left_reg != '0)
                    begin
                        span_addr_reg <= slot_next(span_addr_reg);
                        span_left_reg <= span_left_reg - WW'(1);
                        pend_reg      <= 1'b1;
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_DINIT;
                    end
                end

                // load divider with the span sum magnitude
                S_DINIT:
                begin
                    quo_reg   <= acc_abs[MAG_W-1:0];
                    neg_reg   <= acc_neg;
                    rem_reg   <= '0;
                    dcnt_reg  <= DCNT_W'(MAG_W);
                    state_reg <= S_DIV;
                end

                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    if (!div_diff[WW+1])
                    begin
                        rem_reg <= div_diff[WW-1:0];
                        quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_shift[WW-1:0];
                        quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(1))
                        state_reg <= S_EMIT;
                end

                // hand the word to the output register once it is free
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_reg      <= $signed(quo_signed[SAMPLE_BITS-1:0]);
                        last_reg      <= fin_reg && (out_idx_reg == in_idx_reg);
                        out_idx_reg   <= out_idx_reg + IDX_W'(1);
                        k_reg         <= k_reg + KW'(1);
                        state_reg     <= S_PLAN;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign mean      = mean_reg;
    assign last      = last_reg;

endmodule
